@@ src/fsl_pkg.sv @@
package fsl_pkg;

    // default pool size
    localparam int POOL_SLOTS_DEF = 256;

    // payload widths fixed by the channel formats
    localparam int SLOT_W = 8;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // request beat
    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_in;
    } req_t;

    // response beat
    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              status;
    } rsp_t;

endpackage

@@ src/fsl_chan_if.sv @@
interface fsl_req_if;
    import fsl_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fsl_rsp_if;
    import fsl_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/fsl_ram.sv @@
module fsl_ram #(
    parameter int WIDTH  = 9,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/free_list_slot_allocator.sv @@
// channel  modport  beat contents
// -------  -------  ----------------------------------------------
// req      sink     operation (alloc / free), slot_in
// rsp      source   slot_out, status (done / pool exhausted)
//
// a free or an allocate from an empty pool needs no load state
// an allocate that pops a slot reads the link memory, then reloads the head in ST_LOAD
// after reset a clearing pass writes every link memory entry with req.ready low
// a response waits in an output register; req is taken while it drains in the same cycle
// a stalled rsp holds req.ready low until the waiting beat is taken

module free_list_slot_allocator #(
    parameter int POOL_SLOTS = fsl_pkg::POOL_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fsl_req_if.sink   req,
    fsl_rsp_if.source rsp
);
    import fsl_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int LINK_W = $clog2(POOL_SLOTS + 1);
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_SLOTS);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(POOL_SLOTS - 1);

    // sequencer states
    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  init_idx_reg, init_idx_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_status_reg, out_status_next;

    logic              accept;
    logic              is_free;
    logic              in_range;
    logic              head_empty;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    // link table
    fsl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SLOTS),
        .ADDR_W(IDX_W)
    ) u_link_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // handshake and request decode
    assign req.ready  = (state_reg == ST_RUN) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;
    assign is_free    = (req.payload.operation == OP_FREE);
    assign in_range   = (32'(req.payload.slot_in) < 32'(POOL_SLOTS));
    assign head_empty = (head_reg == LINK_END);

    // memory port control: clearing pass or push on free, pop read on alloc
    always_comb
    begin
        if (state_reg == ST_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = init_idx_reg;
            ram_wdata = LINK_W'(init_idx_reg) + LINK_W'(1);
        end
        else
        begin
            ram_we    = accept && is_free && in_range;
            ram_waddr = IDX_W'(req.payload.slot_in);
            ram_wdata = head_reg;
        end
        ram_re    = accept && !is_free && !head_empty;
        ram_raddr = head_reg[IDX_W-1:0];
    end

    // sequencer and head update
    always_comb
    begin
        state_next    = state_reg;
        init_idx_next = init_idx_reg;
        head_next     = head_reg;
        case (state_reg)
            ST_INIT:
            begin
                init_idx_next = init_idx_reg + IDX_W'(1);
                if (init_idx_reg == IDX_LAST)
                begin
                    state_next    = ST_RUN;
                    init_idx_next = '0;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (is_free)
                    begin
                        if (in_range)
                        begin
                            head_next = LINK_W'(req.payload.slot_in);
                        end
                    end
                    else if (!head_empty)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                head_next  = ram_rdata;
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // response register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (is_free)
            begin
                out_slot_next   = req.payload.slot_in;
                out_status_next = STATUS_DONE;
            end
            else if (head_empty)
            begin
                out_slot_next   = '0;
                out_status_next = STATUS_EMPTY;
            end
            else
            begin
                out_slot_next   = SLOT_W'(head_reg);
                out_status_next = STATUS_DONE;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_idx_reg  <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.payload.slot_out = out_slot_reg;
    assign rsp.payload.status   = out_status_reg;

endmodule

@@ src/fsl_checker.sv @@
module fsl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       operation,
    input logic [7:0] slot_in,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] slot_out,
    input logic       status
);
    import fsl_pkg::*;

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_out) && $stable(status))
        else $error("response changed while stalled");

    // a request is never taken over a response that stays stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("request accepted over a waiting response");

    // a free is echoed in the next cycle with done status
    a_free_echo: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && operation == OP_FREE |=>
            rsp_valid && slot_out == $past(slot_in) && status == STATUS_DONE)
        else $error("free not echoed");

    // exhausted pool reports slot zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_EMPTY |-> slot_out == 8'd0)
        else $error("exhausted response carries a slot");

endmodule

bind free_list_slot_allocator fsl_checker u_fsl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .operation(req.payload.operation),
    .slot_in  (req.payload.slot_in),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .slot_out (rsp.payload.slot_out),
    .status   (rsp.payload.status)
);
